// File: sv/sbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types and constants for the scanned button debouncer.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int BUTTON_COUNT = 5;
  localparam int PIN_W        = 5;
  localparam int THR_W        = 3;
  localparam int IVL_W        = 16;
  localparam int BTN_W        = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int POS_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(5);
  localparam logic [IVL_W-1:0] STEP_RESET      = IVL_W'(1);
  localparam logic [IVL_W-1:0] PAUSE_RESET     = IVL_W'(95);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_STEP      = 2'd1,
    REG_PAUSE     = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [IVL_W-1:0] step;
    logic [IVL_W-1:0] pause;
  } cfg_t;

  typedef struct packed {
    logic             press_event;
    logic [BTN_W-1:0] button_number;
    logic [PIN_W-1:0] levels;
    logic [IVL_W-1:0] interval;
  } res_t;

endpackage

// File: sv/scanned_button_debouncer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanned_button_debouncer_core
// Round-robin counter debouncer with hysteresis and tick interval output.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload
// in       in_valid / in_ready   pin_levels
// out      out_valid / out_ready press_event, button_number,
//                                debounced_levels, next_interval
// cfg      cfg_we                cfg_index, cfg_data
//
// One word per cycle while the output is not stalled; a word passes the input
// register, then the result register, on its way to the output.
// Reset clears counters, flags, scan position and registers to defaults.
// A stalled output holds its word; the input register still takes one more.
// ----------------------------------------------------------------------------
module scanned_button_debouncer_core
  import sbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIN_W-1:0]      pin_levels,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  press_event,
  output logic [BTN_W-1:0]      button_number,
  output logic [PIN_W-1:0]      debounced_levels,
  output logic [IVL_W-1:0]      next_interval,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg;
  res_t             res;
  logic             s1_valid;
  logic [PIN_W-1:0] s1_pins;
  logic             advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  sbd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sbd_scan_update u_upd (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .pins (s1_pins),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      s1_pins <= pin_levels;
    end
    if (advance) begin
      press_event      <= res.press_event;
      button_number    <= res.button_number;
      debounced_levels <= res.levels;
      next_interval    <= res.interval;
    end
  end

endmodule

// File: sv/sbd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_cfg_regs
// Configuration register file: threshold, step interval, round pause.
// ----------------------------------------------------------------------------
module sbd_cfg_regs
  import sbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RESET;
      cfg.step      <= STEP_RESET;
      cfg.pause     <= PAUSE_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_THRESHOLD: cfg.threshold <= cfg_data[THR_W-1:0];
        REG_STEP:      cfg.step      <= cfg_data[IVL_W-1:0];
        REG_PAUSE:     cfg.pause     <= cfg_data[IVL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/sbd_scan_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_scan_update
// Per-tick debounce update: counter, hysteresis flag, scan position.
// ----------------------------------------------------------------------------
module sbd_scan_update
  import sbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [PIN_W-1:0] pins,
  input  cfg_t             cfg,
  output res_t             res
);

  logic [THR_W-1:0]        counters [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] flags;
  logic [POS_W-1:0]        scan_pos;

  logic [BUTTON_COUNT-1:0] pins_ext;
  logic [BUTTON_COUNT-1:0] flags_next;
  logic [THR_W-1:0]        thr;
  logic [THR_W-1:0]        cnt;
  logic [THR_W-1:0]        cnt_next;
  logic [POS_W-1:0]        scan_pos_next;
  logic                    active;
  logic                    flag_next;
  logic                    last;
  logic                    press_evt;
  logic [PIN_W-1:0]        levels;

  always_comb begin
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      pins_ext[i] = (i < PIN_W) ? pins[i % PIN_W] : 1'b0;
    end
  end

  assign thr    = (cfg.threshold == '0) ? THR_W'(1) : cfg.threshold;
  assign active = pins_ext[scan_pos];
  assign cnt    = counters[scan_pos];
  assign last   = (scan_pos == POS_W'(BUTTON_COUNT - 1));

  always_comb begin
    if (active) begin
      cnt_next = (cnt < thr) ? cnt + THR_W'(1) : thr;
    end else begin
      cnt_next = (cnt != '0) ? cnt - THR_W'(1) : cnt;
    end
  end

  always_comb begin
    press_evt = 1'b0;
    flag_next = flags[scan_pos];
    if (!flags[scan_pos]) begin
      if (cnt_next >= thr) begin
        flag_next = 1'b1;
        press_evt = 1'b1;
      end
    end else if (cnt_next == '0) begin
      flag_next = 1'b0;
    end
  end

  always_comb begin
    flags_next           = flags;
    flags_next[scan_pos] = flag_next;
  end

  always_comb begin
    for (int i = 0; i < PIN_W; i++) begin
      levels[i] = (i < BUTTON_COUNT) ? flags_next[i % BUTTON_COUNT] : 1'b0;
    end
  end

  assign scan_pos_next = last ? '0 : scan_pos + POS_W'(1);
  assign res           = {press_evt, BTN_W'(scan_pos), levels, last ? cfg.pause : cfg.step};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        counters[i] <= '0;
      end
      flags    <= '0;
      scan_pos <= '0;
    end else if (en) begin
      counters[scan_pos] <= cnt_next;
      flags              <= flags_next;
      scan_pos           <= scan_pos_next;
    end
  end

endmodule

// File: sv/sbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_checker
// Port-level checks for the scanned button debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module sbd_checker
  import sbd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [PIN_W-1:0]      pin_levels,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  press_event,
  input logic [BTN_W-1:0]      button_number,
  input logic [PIN_W-1:0]      debounced_levels,
  input logic [IVL_W-1:0]      next_interval
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(pin_levels))
    else $error("waiting input word changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(button_number)
      && $stable(next_interval) && $stable(debounced_levels))
    else $error("stalled output word changed");

  a_btn_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(button_number) < BUTTON_COUNT))
    else $error("button number out of range");

  a_event_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && press_event && (int'(button_number) < PIN_W)
      |-> debounced_levels[button_number])
    else $error("press event without debounced flag");

endmodule

bind scanned_button_debouncer_core sbd_checker u_sbd_checker (.*);
